// ===== rtl/font_upload_retransmit_window_assert.svh =====
// ----------------------------------------------------------------------------
// font_upload_retransmit_window_assert.svh
// assertion macros used by the upload window rtl
// ----------------------------------------------------------------------------
`ifndef FONT_UPLOAD_RETRANSMIT_WINDOW_ASSERT_SVH
`define FONT_UPLOAD_RETRANSMIT_WINDOW_ASSERT_SVH

// antecedent implies consequent on the same edge
`define FURW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("furw assertion failed");

// expression must never hold
`define FURW_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("furw assertion failed");

`endif

// ===== rtl/furw_pkg.sv =====
// ----------------------------------------------------------------------------
// furw_pkg
// shared types and constants of the upload request window
// ----------------------------------------------------------------------------
package furw_pkg;

  // width of the internal next-index counter
  localparam int IndexBits = 8;

  localparam logic [7:0] LastCharReset = 8'hFF;
  localparam logic [7:0] MaskSeed      = 8'h80;
  localparam logic [7:0] MaskOldest    = 8'h02;
  localparam logic [7:0] MaskMidSel    = 8'h11;
  localparam logic [7:0] MaskMidMiss   = 8'h10;
  localparam logic [7:0] MaskFirstUsed = 8'h01;
  localparam logic [7:0] MaskScan      = 8'hFE;
  localparam int         OldestBack    = 6;
  localparam int         MidBack       = 3;
  localparam int         ScanBase      = 7;

  typedef enum logic [1:0] {
    OP_ENTER   = 2'd0,
    OP_RECEIVE = 2'd1,
    OP_REQUEST = 2'd2,
    OP_STATUS  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_index;
    logic       armed;
    logic       config_mode;
  } furw_item_t;

  typedef struct packed {
    logic       request_valid;
    logic [7:0] request_index;
    logic       upload_done;
    logic       nvm_write;
    logic [7:0] nvm_index;
    logic       in_upload_mode;
  } furw_result_t;

endpackage

// ===== rtl/font_upload_retransmit_window.sv =====
// ----------------------------------------------------------------------------
// font_upload_retransmit_window
// path: an accepted item passes the input register, then the result register, to out_valid
// throughput: one item per cycle while out_ready is high, set by the single input and result register
// reset: window mask, counter and mode flag clear, last_char returns to 255
// ----------------------------------------------------------------------------
`include "font_upload_retransmit_window_assert.svh"

module font_upload_retransmit_window (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_index,
  input  logic       in_armed,
  input  logic       in_config_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_request_valid,
  output logic [7:0] out_request_index,
  output logic       out_upload_done,
  output logic       out_nvm_write,
  output logic [7:0] out_nvm_index,
  output logic       out_in_upload_mode
);

  logic                   last_char_r;
  logic [7:0]             last_r;
  logic                   in_v_r;
  furw_pkg::furw_item_t   item_r;
  logic                   out_v_r;
  furw_pkg::furw_result_t res_r;
  furw_pkg::furw_result_t res_nxt;
  logic                   step;

  // item moves from input register to result register
  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= furw_pkg::LastCharReset;
      last_char_r <= 1'b0;
    end else begin
      last_char_r <= cfg_we;
      if (cfg_we) begin
        last_r <= cfg_wdata;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation   <= furw_pkg::op_t'(in_operation);
      item_r.char_index  <= in_char_index;
      item_r.armed       <= in_armed;
      item_r.config_mode <= in_config_mode;
    end
  end

  furw_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item_r),
    .last_char (last_r),
    .result    (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_request_valid  = res_r.request_valid;
  assign out_request_index  = res_r.request_index;
  assign out_upload_done    = res_r.upload_done;
  assign out_nvm_write      = res_r.nvm_write;
  assign out_nvm_index      = res_r.nvm_index;
  assign out_in_upload_mode = res_r.in_upload_mode;

  // checks
  `FURW_ASSERT_NEVER(a_req_and_write, out_v_r && res_r.request_valid && res_r.nvm_write)
  `FURW_ASSERT_IMPL(a_done_leaves_mode, out_v_r && res_r.upload_done,
                    !res_r.in_upload_mode && !res_r.request_valid)
  `FURW_ASSERT_IMPL(a_write_in_mode, out_v_r && res_r.nvm_write, res_r.in_upload_mode)
  `FURW_ASSERT_IMPL(a_stall_only_when_full, !in_ready, in_v_r && out_v_r && !out_ready)
  `FURW_ASSERT_IMPL(a_cfg_taken, last_char_r, last_r == $past(cfg_wdata))

endmodule

// ===== rtl/furw_win.sv =====
// ----------------------------------------------------------------------------
// furw_win
// window state registers and the per-item update and result logic
// ----------------------------------------------------------------------------
module furw_win (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  furw_pkg::furw_item_t  item,
  input  logic [7:0]            last_char,
  output furw_pkg::furw_result_t result
);

  localparam int IW = furw_pkg::IndexBits;

  logic [7:0]    mask_r, mask_nxt;
  logic [IW-1:0] next_r, next_nxt;
  logic          active_r, active_nxt;

  logic [IW-1:0] offset;
  logic          in_window;
  logic [7:0]    hit_bit;
  logic          at_last;
  logic [7:0]    rest;
  logic [2:0]    scan_pos;
  logic [IW-1:0] idx_oldest, idx_mid, idx_scan;

  // receive window lookup
  assign offset    = next_r - IW'(item.char_index);
  assign in_window = (offset[IW-1:3] == '0);
  assign hit_bit   = furw_pkg::MaskSeed >> offset[2:0];

  // request helpers
  assign at_last    = (next_r == IW'(last_char));
  assign rest       = mask_r & furw_pkg::MaskScan;
  assign idx_oldest = next_r - IW'(furw_pkg::OldestBack);
  assign idx_mid    = next_r - IW'(furw_pkg::MidBack);
  assign idx_scan   = next_r + IW'(scan_pos) - IW'(furw_pkg::ScanBase);

  // lowest outstanding slot among bits 1..7
  always_comb begin
    scan_pos = 3'd7;
    for (int i = 7; i >= 1; i--) begin
      if (rest[i]) begin
        scan_pos = 3'(i);
      end
    end
  end

  // operation decode
  always_comb begin
    mask_nxt   = mask_r;
    next_nxt   = next_r;
    active_nxt = active_r;
    result     = '0;
    unique case (item.operation)
      furw_pkg::OP_ENTER: begin
        if (!item.armed && !item.config_mode && !active_r) begin
          mask_nxt   = furw_pkg::MaskSeed;
          active_nxt = 1'b1;
        end
      end
      furw_pkg::OP_RECEIVE: begin
        if (active_r && in_window && ((mask_r & hit_bit) != 8'h00)) begin
          mask_nxt         = mask_r & ~hit_bit;
          result.nvm_write = 1'b1;
          result.nvm_index = item.char_index;
        end
      end
      furw_pkg::OP_REQUEST: begin
        if (!at_last) begin
          result.request_valid = 1'b1;
          priority if ((mask_r & furw_pkg::MaskOldest) != 8'h00) begin
            result.request_index = idx_oldest[7:0];
          end else if ((mask_r & furw_pkg::MaskMidSel) == furw_pkg::MaskMidMiss) begin
            mask_nxt             = mask_r | furw_pkg::MaskFirstUsed;
            result.request_index = idx_mid[7:0];
          end else begin
            mask_nxt             = (mask_r >> 1) | furw_pkg::MaskSeed;
            result.request_index = next_r[7:0];
            next_nxt             = next_r + IW'(1);
          end
        end else if (rest == 8'h00) begin
          active_nxt         = 1'b0;
          result.upload_done = 1'b1;
        end else begin
          result.request_valid = 1'b1;
          result.request_index = idx_scan[7:0];
        end
      end
      furw_pkg::OP_STATUS: begin
      end
      default: begin
      end
    endcase
    result.in_upload_mode = active_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      next_r   <= '0;
      active_r <= 1'b0;
    end else if (step) begin
      mask_r   <= mask_nxt;
      next_r   <= next_nxt;
      active_r <= active_nxt;
    end
  end

endmodule
